// File: hw/rtl/srm_pkg.sv
// Package for the SRM spiking neuron update block: widths, reset values,
// register map, configuration and status structs, saturation helper.
// No dependencies.
package srm_pkg;

  // Default parameter values
  localparam int MS_TICKS_DEF      = 1000;
  localparam int FRACTION_BITS_DEF = 16;

  // Field widths
  localparam int Q_W     = 32;
  localparam int TAU_W   = 31;
  localparam int TIME_W  = 32;
  localparam int SPAN_W  = 16;
  localparam int NUM_W   = Q_W + SPAN_W;
  localparam int SAT_W   = 43;

  // Leak term is capped at 2^40, so 41 quotient bits are kept
  localparam int                 TERM_W   = 41;
  localparam logic [TERM_W-1:0]  TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_REST   = 2'd0,
    REG_THRESH = 2'd1,
    REG_TAU    = 2'd2,
    REG_REFR   = 2'd3
  } reg_idx_t;

  // Register reset values
  localparam logic [Q_W-1:0]    RST_REST   = 32'd0;
  localparam logic [Q_W-1:0]    RST_THRESH = 32'd65536;
  localparam logic [TAU_W-1:0]  RST_TAU    = 31'd655360;
  localparam logic [TIME_W-1:0] RST_REFR   = 32'd0;

  // Request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_STIM = 1'b1;

  typedef struct packed {
    logic [Q_W-1:0]    rest;
    logic [Q_W-1:0]    thresh;
    logic [TAU_W-1:0]  tau;
    logic [TIME_W-1:0] refr_ticks;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } leak_sts_t;

  // Clamp a wide signed value to signed Q16.16
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = 43'sd2147483647;
    lo = -43'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[Q_W-1:0];
  endfunction

endpackage

// File: hw/rtl/srm_ifs.sv
// Valid/ready channel interfaces for the neuron block: request words in,
// result words out. Depends on nothing.
interface srm_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [31:0]        time_now;
  logic [15:0]        tick_span;
  logic signed [31:0] stim_value;

  modport source (output valid, req_type, time_now, tick_span, stim_value, input ready);
  modport sink   (input valid, req_type, time_now, tick_span, stim_value, output ready);
endinterface

interface srm_out_if;
  logic               valid;
  logic               ready;
  logic               spike;
  logic [31:0]        spike_time;
  logic signed [31:0] potential_out;
  logic               in_refractory;

  modport source (output valid, spike, spike_time, potential_out, in_refractory,
                  input ready);
  modport sink   (input valid, spike, spike_time, potential_out, in_refractory,
                  output ready);
endinterface

// File: hw/rtl/srm_cfg.sv
// APB register file for the neuron: rest potential, threshold, time
// constant and refractory period. Depends on srm_pkg.
module srm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [srm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [srm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output srm_pkg::cfg_t                   cfg
);

  logic              wr;
  srm_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = srm_pkg::reg_idx_t'(paddr[3:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rest       <= srm_pkg::RST_REST;
      cfg.thresh     <= srm_pkg::RST_THRESH;
      cfg.tau        <= srm_pkg::RST_TAU;
      cfg.refr_ticks <= srm_pkg::RST_REFR;
    end else if (wr) begin
      case (idx)
        srm_pkg::REG_REST:   cfg.rest       <= pwdata;
        srm_pkg::REG_THRESH: cfg.thresh     <= pwdata;
        srm_pkg::REG_TAU:    cfg.tau        <= pwdata[srm_pkg::TAU_W-1:0];
        srm_pkg::REG_REFR:   cfg.refr_ticks <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      srm_pkg::REG_REST:   prdata = cfg.rest;
      srm_pkg::REG_THRESH: prdata = cfg.thresh;
      srm_pkg::REG_TAU:    prdata = {1'b0, cfg.tau};
      srm_pkg::REG_REFR:   prdata = cfg.refr_ticks;
      default:             prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/srm_leak_div.sv
// Shared leak-term unit: |x-base| * span * 2^F / (2 * ms_ticks * tau),
// capped at 2^40, by restoring division one quotient bit a cycle.
// Depends on srm_pkg.
module srm_leak_div #(
  parameter int MS_TICKS      = srm_pkg::MS_TICKS_DEF,
  parameter int FRACTION_BITS = srm_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [srm_pkg::Q_W-1:0]        mag,
  input  logic [srm_pkg::SPAN_W-1:0]     span,
  input  logic [srm_pkg::TAU_W-1:0]      tau,
  output logic [srm_pkg::TERM_W-1:0]     term,
  output srm_pkg::leak_sts_t             sts
);

  localparam int K      = 2 * MS_TICKS;
  localparam int K_W    = $clog2(K + 1);
  localparam int DEN_W  = srm_pkg::TAU_W + K_W;
  localparam int NUM_W  = srm_pkg::NUM_W;
  localparam int DVD_W  = NUM_W + FRACTION_BITS;
  localparam int QW     = srm_pkg::TERM_W;
  localparam int PRE_W  = DVD_W - QW;
  localparam int CNT_W  = $clog2(QW);

  typedef enum logic [4:0] {
    D_IDLE  = 5'b00001,
    D_LOAD  = 5'b00010,
    D_CHECK = 5'b00100,
    D_RUN   = 5'b01000,
    D_DONE  = 5'b10000
  } dstate_t;

  dstate_t                  state, state_next;
  logic [NUM_W-1:0]         num;
  logic [DEN_W-1:0]         den;
  logic [DEN_W-1:0]         rem;
  logic [QW-1:0]            lo;
  logic [QW-1:0]            quo;
  logic                     ovf;
  logic [CNT_W-1:0]         cnt;
  logic [srm_pkg::TAU_W-1:0] tau_eff;
  logic [DVD_W-1:0]         dividend;
  logic [PRE_W-1:0]         pre;
  logic [DEN_W:0]           trial;
  logic                     ge;
  logic                     last_bit;

  assign tau_eff  = (tau == '0) ? srm_pkg::TAU_W'(1) : tau;
  assign dividend = {num, {FRACTION_BITS{1'b0}}};
  assign pre      = dividend[DVD_W-1 -: PRE_W];
  assign trial    = {rem, lo[QW-1]};
  assign ge       = trial >= {1'b0, den};
  assign last_bit = cnt == CNT_W'(QW - 1);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      D_IDLE:  if (start) state_next = D_LOAD;
      D_LOAD:  state_next = D_CHECK;
      D_CHECK: state_next = (DEN_W'(pre) >= den) ? D_DONE : D_RUN;
      D_RUN:   if (last_bit) state_next = D_DONE;
      D_DONE:  state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: products, then overflow check on the top bits, then bit loop
  always_ff @(posedge clk) begin
    case (state)
      D_LOAD: begin
        num <= NUM_W'(mag) * NUM_W'(span);
        den <= DEN_W'(tau_eff) * DEN_W'(K);
        ovf <= 1'b0;
      end
      D_CHECK: begin
        // quotient at or above 2^41 when the top bits already hold a divisor
        ovf <= DEN_W'(pre) >= den;
        rem <= DEN_W'(pre);
        lo  <= dividend[QW-1:0];
        quo <= '0;
        cnt <= '0;
      end
      D_RUN: begin
        rem <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
        quo <= {quo[QW-2:0], ge};
        lo  <= {lo[QW-2:0], 1'b0};
        cnt <= cnt + CNT_W'(1);
      end
      default: ;
    endcase
  end

  assign term     = (ovf || quo[QW-1]) ? srm_pkg::TERM_CAP : quo;
  assign sts.busy = state != D_IDLE;
  assign sts.done = state == D_DONE;

endmodule

// File: hw/rtl/srm_spiking_neuron_update.sv
// Top level of the SRM spiking neuron: sequencer, neuron state and output
// register around the APB registers and the shared leak-term divider.
// Depends on srm_pkg, srm_ifs, srm_cfg and srm_leak_div.
//
//   channel  | dir | handshake            | word
//   in_ch    | in  | valid/ready          | req_type, time_now, tick_span, stim_value
//   out_ch   | out | valid/ready          | spike, spike_time, potential_out, in_refractory
//   apb      | in  | psel/penable, pready | paddr, pwdata, prdata
//
// A tick passes check, fire (outside the refractory window only), two Euler
// half-steps (delta, start, wait, apply) and done. Each half-step waits on the
// divider's bit loop, skipped when the leak term overflows. A stimulus word
// goes straight to done. in_ch is ready only while the sequencer is idle.
// The result register holds its word while out_ch stalls; the next word is
// accepted meanwhile. Synchronous reset clears state and the result valid.
module srm_spiking_neuron_update #(
  parameter int MS_TICKS      = srm_pkg::MS_TICKS_DEF,
  parameter int FRACTION_BITS = srm_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  srm_in_if.sink                          in_ch,
  srm_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [srm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [srm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int QW = srm_pkg::Q_W;
  localparam int SW = srm_pkg::SAT_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CHECK = 8'b00000010,
    S_FIRE  = 8'b00000100,
    S_DELTA = 8'b00001000,
    S_START = 8'b00010000,
    S_WAIT  = 8'b00100000,
    S_APPLY = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t                        state, state_next;
  srm_pkg::cfg_t                 cfg;
  srm_pkg::leak_sts_t            div_sts;
  logic [srm_pkg::TERM_W-1:0]    term;

  // Neuron state
  logic signed [QW-1:0]          vm;
  logic signed [QW-1:0]          pend;
  logic [srm_pkg::TIME_W-1:0]    last_spike;

  // Per-item working registers
  logic [srm_pkg::TIME_W-1:0]    now_r;
  logic [srm_pkg::SPAN_W-1:0]    span_r;
  logic signed [QW-1:0]          x;
  logic signed [QW-1:0]          base;
  logic                          neg;
  logic [QW-1:0]                 mag;
  logic                          half;
  logic                          refr;
  logic                          fired;
  logic [srm_pkg::TIME_W-1:0]    stamp;

  // Result register
  logic                          out_valid;
  logic                          out_spike;
  logic [srm_pkg::TIME_W-1:0]    out_time;
  logic signed [QW-1:0]          out_pot;
  logic                          out_refr;

  logic                          in_acc;
  logic                          out_free;
  logic                          outside;
  logic [srm_pkg::TIME_W-1:0]    fire_time;
  logic signed [QW:0]            delta;
  logic signed [SW-1:0]          term_ext;
  logic signed [QW-1:0]          applied;
  logic signed [QW-1:0]          merged;
  logic signed [QW-1:0]          pend_add;

  srm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srm_leak_div #(
    .MS_TICKS      (MS_TICKS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_START),
    .mag   (mag),
    .span  (span_r),
    .tau   (cfg.tau),
    .term  (term),
    .sts   (div_sts)
  );

  assign in_ch.ready = state == S_IDLE;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  // Combinational helpers
  assign outside   = (now_r - last_spike) > cfg.refr_ticks;
  assign fire_time = now_r + srm_pkg::TIME_W'(span_r);
  assign delta     = (QW+1)'(x) - (QW+1)'(base);
  assign term_ext  = signed'({{(SW - srm_pkg::TERM_W){1'b0}}, term});
  assign applied   = srm_pkg::sat_q(neg ? SW'(x) + term_ext : SW'(x) - term_ext);
  assign merged    = srm_pkg::sat_q(SW'(vm) + SW'(pend));
  assign pend_add  = srm_pkg::sat_q(SW'(pend) + SW'(in_ch.stim_value));

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (in_ch.req_type == srm_pkg::REQ_STIM) ? S_DONE : S_CHECK;
        end
      end
      S_CHECK: state_next = outside ? S_FIRE : S_DELTA;
      S_FIRE:  state_next = S_DELTA;
      S_DELTA: state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT:  if (div_sts.done) state_next = S_APPLY;
      S_APPLY: state_next = half ? S_DONE : S_DELTA;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Neuron state
  always_ff @(posedge clk) begin
    if (rst) begin
      vm         <= signed'(srm_pkg::RST_REST);
      pend       <= '0;
      last_spike <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && in_ch.req_type == srm_pkg::REQ_STIM) begin
            pend <= pend_add;
          end
        end
        S_CHECK: if (outside) pend <= '0;
        S_FIRE:  if (x > signed'(cfg.thresh)) last_spike <= fire_time;
        S_APPLY: begin
          if (half) begin
            if (refr) begin
              pend <= applied;
            end else begin
              vm <= applied;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          now_r  <= in_ch.time_now;
          span_r <= in_ch.tick_span;
          fired  <= 1'b0;
          stamp  <= '0;
          refr   <= 1'b0;
        end
      end
      S_CHECK: begin
        half <= 1'b0;
        if (outside) begin
          x <= merged;
        end else begin
          refr <= 1'b1;
          x    <= pend;
          base <= '0;
        end
      end
      S_FIRE: begin
        base <= signed'(cfg.rest);
        if (x > signed'(cfg.thresh)) begin
          x     <= signed'(cfg.rest);
          fired <= 1'b1;
          stamp <= fire_time;
        end
      end
      S_DELTA: begin
        neg <= delta[QW];
        mag <= delta[QW] ? QW'(-delta) : QW'(delta);
      end
      S_APPLY: begin
        x    <= applied;
        half <= 1'b1;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_spike <= fired;
      out_time  <= stamp;
      out_pot   <= vm;
      out_refr  <= refr;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.spike         = out_spike;
  assign out_ch.spike_time    = out_time;
  assign out_ch.potential_out = out_pot;
  assign out_ch.in_refractory = out_refr;

endmodule

// File: hw/rtl/srm_checker.sv
// Port-level checks for the neuron block, attached to the top level by bind.
// Depends on srm_spiking_neuron_update and srm_pkg.
module srm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_spike,
  input logic [31:0] out_spike_time,
  input logic [31:0] out_potential,
  input logic        out_in_refractory
);

  // One word in flight: busy right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an accepted word");

  // A result appears together with the return to idle
  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while the sequencer is still busy");

  // A stimulus word on an empty output gives a quiet result
  a_stim_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_req_type == srm_pkg::REQ_STIM && !out_valid
    |=> ##1 (out_valid && !out_spike && !out_in_refractory && out_spike_time == '0))
    else $error("stimulus word did not give a quiet result");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_spike) &&
    $stable(out_spike_time) && $stable(out_potential) && $stable(out_in_refractory))
    else $error("stalled result word changed");

endmodule

bind srm_spiking_neuron_update srm_checker u_srm_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_req_type       (in_ch.req_type),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_spike         (out_ch.spike),
  .out_spike_time    (out_ch.spike_time),
  .out_potential     (out_ch.potential_out),
  .out_in_refractory (out_ch.in_refractory)
);
